FILE: hw/rtl/csb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Comment-strip brace lexer package
// Shared constants, character codes, result kinds and small helper types.
// ----------------------------------------------------------------------------
package csb_pkg;

    // Default sizes handed to the top level.
    localparam int STACK_DEPTH_DEF = 32;
    localparam int POS_BITS_DEF    = 20;
    localparam int ID_BITS_DEF     = 16;

    // Result queue depth; an input item may produce two results.
    localparam int Q_DEPTH = 4;

    // Width of the result kind field.
    localparam int KIND_BITS = 3;

    // Result kinds.
    localparam logic [KIND_BITS-1:0] KIND_IDENT     = 3'd0;
    localparam logic [KIND_BITS-1:0] KIND_OPEN      = 3'd1;
    localparam logic [KIND_BITS-1:0] KIND_CLOSE     = 3'd2;
    localparam logic [KIND_BITS-1:0] KIND_UNMATCHED = 3'd3;
    localparam logic [KIND_BITS-1:0] KIND_OVERFLOW  = 3'd4;

    // Character codes.
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_VT     = 8'h0B;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_SPACE  = 8'h20;

    // Stack operation requested by the lexer.
    typedef struct packed {
        logic push;
        logic pop;
    } stack_op_t;

    // Stack status seen by the lexer.
    typedef struct packed {
        logic empty;
        logic full;
    } stack_stat_t;

    // Letters and underscore may start an identifier.
    function automatic logic is_alpha(input logic [7:0] c);
        return (c inside {[8'h61:8'h7A], [8'h41:8'h5A], CH_UNDER});
    endfunction

    // Decimal digits may continue an identifier.
    function automatic logic is_digit(input logic [7:0] c);
        return (c inside {[8'h30:8'h39]});
    endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/csb_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Comment-strip brace lexer channels
// Valid/ready channel for source bytes and for lexer results.
// ----------------------------------------------------------------------------

// Source byte channel.
interface csb_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       last_char;

    modport source (output valid, output ch, output last_char, input ready);
    modport sink   (input valid, input ch, input last_char, output ready);
endinterface

// Result channel.
interface csb_out_if #(
    parameter int POS_BITS = csb_pkg::POS_BITS_DEF,
    parameter int ID_BITS  = csb_pkg::ID_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic [csb_pkg::KIND_BITS-1:0] kind;
    logic [POS_BITS-1:0]           start_pos;
    logic [POS_BITS-1:0]           end_pos;
    logic [ID_BITS-1:0]            block_id;
    logic [ID_BITS-1:0]            parent_id;
    logic                          has_link;
    logic [POS_BITS-1:0]           line;
    logic                          last_of_run;

    modport source (output valid, output kind, output start_pos, output end_pos,
                    output block_id, output parent_id, output has_link, output line,
                    output last_of_run, input ready);
    modport sink   (input valid, input kind, input start_pos, input end_pos,
                    input block_id, input parent_id, input has_link, input line,
                    input last_of_run, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/comment_strip_brace_lexer.sv
`timescale 1ns / 1ps
`default_nettype none
// Results of a source byte are registered in the result queue and leave from its head.
// Throughput: one source byte per cycle while the queue has room for two results; a byte
// with two results hands them out in turn, and a four-entry result queue absorbs such bursts.
// The block stack keeps its top entry in registers, so braces on consecutive bytes go on.
// Reset clears mode, counters but line (set to 1), stack depth and queue; stack memory is not cleared.
// ----------------------------------------------------------------------------
// Comment-strip brace lexer
// Strips comments and redundant whitespace from a byte stream and reports
// identifiers, block opens and closes and brace errors.
// ----------------------------------------------------------------------------
module comment_strip_brace_lexer #(
    parameter int STACK_DEPTH = csb_pkg::STACK_DEPTH_DEF,
    parameter int POS_BITS    = csb_pkg::POS_BITS_DEF,
    parameter int ID_BITS     = csb_pkg::ID_BITS_DEF
) (
    input wire          clk,
    input wire          rst_n,
    csb_in_if.sink      byte_in,
    csb_out_if.source   tok_out
);
    localparam int DATA_W = csb_pkg::KIND_BITS + 3 * POS_BITS + 2 * ID_BITS + 2;

    logic                 fire;
    logic                 room2;
    csb_pkg::stack_op_t   op;
    csb_pkg::stack_stat_t stat;
    logic [ID_BITS-1:0]   tos;
    logic [ID_BITS-1:0]   push_id;
    logic [1:0]           res_n;
    logic [DATA_W-1:0]    res0;
    logic [DATA_W-1:0]    res1;
    logic [DATA_W-1:0]    head;

    // A byte is taken whenever the queue has room for two results.
    assign byte_in.ready = room2;
    assign fire          = byte_in.valid && room2;

    csb_lex #(
        .POS_BITS (POS_BITS),
        .ID_BITS  (ID_BITS),
        .DATA_W   (DATA_W)
    ) u_lex (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .ch        (byte_in.ch),
        .last_char (byte_in.last_char),
        .stat      (stat),
        .tos       (tos),
        .op        (op),
        .push_id   (push_id),
        .res_n     (res_n),
        .res0      (res0),
        .res1      (res1)
    );

    csb_stack #(
        .STACK_DEPTH (STACK_DEPTH),
        .ID_BITS     (ID_BITS)
    ) u_stack (
        .clk     (clk),
        .rst_n   (rst_n),
        .op      (op),
        .push_id (push_id),
        .stat    (stat),
        .tos     (tos)
    );

    csb_outq #(
        .DATA_W (DATA_W)
    ) u_outq (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_n     (res_n),
        .wr_data0 (res0),
        .wr_data1 (res1),
        .room2    (room2),
        .rd_valid (tok_out.valid),
        .rd_ready (tok_out.ready),
        .rd_data  (head)
    );

    // Unpack the queue head onto the result channel.
    assign {tok_out.kind, tok_out.start_pos, tok_out.end_pos, tok_out.block_id,
            tok_out.parent_id, tok_out.has_link, tok_out.line, tok_out.last_of_run} = head;

    // A pop is never requested on an empty stack.
    assert property (@(posedge clk) disable iff (!rst_n) op.pop |-> !stat.empty)
        else $error("stack pop while empty");

    // A push is never requested on a full stack, nor together with a pop.
    assert property (@(posedge clk) disable iff (!rst_n)
                     op.push |-> (!stat.full && !op.pop))
        else $error("stack push while full or with pop");

    // The pushed id is the top of stack on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
                     op.push |=> (tos == $past(push_id)))
        else $error("stack top does not match pushed id");

    // Results are only written when a byte is transferred.
    assert property (@(posedge clk) disable iff (!rst_n) (res_n != 2'd0) |-> fire)
        else $error("results written without byte transfer");

endmodule
`default_nettype wire

FILE: hw/rtl/csb_stack.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Block id stack
// Open block ids in a synchronous memory, with the top and the entry under it
// held in registers so a push or pop is possible on every cycle.
// ----------------------------------------------------------------------------
module csb_stack #(
    parameter int STACK_DEPTH = csb_pkg::STACK_DEPTH_DEF,
    parameter int ID_BITS     = csb_pkg::ID_BITS_DEF
) (
    input  wire                       clk,
    input  wire                       rst_n,
    input  wire csb_pkg::stack_op_t   op,
    input  wire  [ID_BITS-1:0]        push_id,
    output csb_pkg::stack_stat_t      stat,
    output logic [ID_BITS-1:0]        tos
);
    localparam int AW = $clog2(STACK_DEPTH);
    localparam int DW = $clog2(STACK_DEPTH + 1);

    logic [ID_BITS-1:0] mem [STACK_DEPTH];
    logic [ID_BITS-1:0] rdata_reg;
    logic [ID_BITS-1:0] tos_reg;
    logic [ID_BITS-1:0] below_reg;
    logic               below_sel_reg;
    logic [DW-1:0]      depth_reg;
    logic [DW-1:0]      rd_full_addr;
    logic [AW-1:0]      rd_addr;
    logic [AW-1:0]      wr_addr;
    logic               rd_en;
    logic [ID_BITS-1:0] below;

    // The entry under the top comes from the memory right after a pop.
    assign below = below_sel_reg ? rdata_reg : below_reg;

    // A pop at depth d fetches entry d-3, the new second entry.
    assign rd_full_addr = depth_reg - DW'(3);
    assign rd_addr      = rd_full_addr[AW-1:0];
    assign rd_en        = op.pop && (depth_reg >= DW'(3));
    assign wr_addr      = depth_reg[AW-1:0];

    assign stat.empty = (depth_reg == '0);
    assign stat.full  = (depth_reg == DW'(STACK_DEPTH));
    assign tos        = tos_reg;

    // Memory write and registered read.
    always_ff @(posedge clk)
    begin
        if (op.push)
        begin
            mem[wr_addr] <= push_id;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    // Top and second entry registers.
    always_ff @(posedge clk)
    begin
        if (op.push)
        begin
            tos_reg   <= push_id;
            below_reg <= tos_reg;
        end
        else if (op.pop)
        begin
            tos_reg <= below;
        end
    end

    // Depth and read-select control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg     <= '0;
            below_sel_reg <= 1'b0;
        end
        else if (op.push)
        begin
            depth_reg     <= depth_reg + DW'(1);
            below_sel_reg <= 1'b0;
        end
        else if (op.pop)
        begin
            depth_reg     <= depth_reg - DW'(1);
            below_sel_reg <= 1'b1;
        end
    end

endmodule
`default_nettype wire

FILE: hw/rtl/csb_outq.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Result queue
// Small queue that takes up to two results per cycle and hands out one.
// ----------------------------------------------------------------------------
module csb_outq #(
    parameter int DATA_W = 8
) (
    input  wire               clk,
    input  wire               rst_n,
    input  wire  [1:0]        wr_n,
    input  wire  [DATA_W-1:0] wr_data0,
    input  wire  [DATA_W-1:0] wr_data1,
    output logic              room2,
    output logic              rd_valid,
    input  wire               rd_ready,
    output logic [DATA_W-1:0] rd_data
);
    localparam int PW = $clog2(csb_pkg::Q_DEPTH);
    localparam int CW = $clog2(csb_pkg::Q_DEPTH + 1);

    logic [DATA_W-1:0] slot_reg [csb_pkg::Q_DEPTH];
    logic [PW-1:0]     wr_ptr_reg;
    logic [PW-1:0]     wr_ptr_next;
    logic [PW-1:0]     rd_ptr_reg;
    logic [CW-1:0]     count_reg;
    logic [CW-1:0]     count_next;
    logic              rd_xfer;
    logic [PW-1:0]     wr_ptr1;

    assign rd_valid = (count_reg != '0);
    assign rd_data  = slot_reg[rd_ptr_reg];
    assign room2    = (count_reg <= CW'(csb_pkg::Q_DEPTH - 2));
    assign rd_xfer  = rd_valid && rd_ready;
    assign wr_ptr1  = wr_ptr_reg + PW'(1);

    // Pointer and fill-level arithmetic.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PW'(wr_n);
        count_next  = count_reg + CW'(wr_n) - CW'(rd_xfer);
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (wr_n != 2'd0)
        begin
            slot_reg[wr_ptr_reg] <= wr_data0;
        end
        if (wr_n == 2'd2)
        begin
            slot_reg[wr_ptr1] <= wr_data1;
        end
    end

    // Queue control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            count_reg  <= count_next;
            if (rd_xfer)
            begin
                rd_ptr_reg <= rd_ptr_reg + PW'(1);
            end
        end
    end

endmodule
`default_nettype wire

FILE: hw/rtl/csb_lex.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Lexer core
// Comment and whitespace filter plus identifier and brace scanner. Handles one
// source byte per cycle while fire is high and produces up to two packed results.
// ----------------------------------------------------------------------------
module csb_lex #(
    parameter int POS_BITS = csb_pkg::POS_BITS_DEF,
    parameter int ID_BITS  = csb_pkg::ID_BITS_DEF,
    parameter int DATA_W   = csb_pkg::KIND_BITS + 3 * POS_BITS + 2 * ID_BITS + 2
) (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    fire,
    input  wire  [7:0]             ch,
    input  wire                    last_char,
    input  wire csb_pkg::stack_stat_t stat,
    input  wire  [ID_BITS-1:0]     tos,
    output csb_pkg::stack_op_t     op,
    output logic [ID_BITS-1:0]     push_id,
    output logic [1:0]             res_n,
    output logic [DATA_W-1:0]      res0,
    output logic [DATA_W-1:0]      res1
);
    typedef enum logic [2:0] {
        M_NORMAL,
        M_SLASH,
        M_LINE,
        M_BLOCK,
        M_STAR
    } mode_t;

    mode_t               mode_reg;
    mode_t               mode_mid;
    mode_t               mode_next;
    logic [7:0]          last_kept_reg;
    logic [7:0]          last_kept_next;
    logic [POS_BITS-1:0] kept_reg;
    logic [POS_BITS-1:0] kept_mid;
    logic [POS_BITS-1:0] kept_next;
    logic [POS_BITS-1:0] line_reg;
    logic [POS_BITS-1:0] line_next;
    logic                ident_reg;
    logic                ident_mid;
    logic                ident_next;
    logic [POS_BITS-1:0] ident_start_reg;
    logic [POS_BITS-1:0] ident_start_next;
    logic [ID_BITS-1:0]  next_id_reg;

    logic                drop;
    logic                keep_s;
    logic                keep_c;
    logic                c_kept;
    logic                c_alpha;
    logic                c_digit;
    logic                e1_v;
    logic [POS_BITS-1:0] e1_end;
    logic                e2_v;
    logic                b_v;
    logic [csb_pkg::KIND_BITS-1:0] b_kind;
    logic [ID_BITS-1:0]  b_block;
    logic [ID_BITS-1:0]  b_parent;
    logic                b_link;
    logic [ID_BITS-1:0]  encl_id;
    logic                is_open;
    logic                is_close;
    logic [DATA_W-1:0]   e1_pack;
    logic [DATA_W-1:0]   e2_pack;
    logic [DATA_W-1:0]   b_pack;
    logic [DATA_W-2:0]   tail_pack;

    assign c_alpha = csb_pkg::is_alpha(ch);
    assign c_digit = csb_pkg::is_digit(ch);
    assign drop    = (ch == csb_pkg::CH_TAB) || (ch == csb_pkg::CH_VT);
    assign encl_id = stat.empty ? '0 : tos;

    // Comment filter: decide which bytes reach the scanner.
    always_comb
    begin
        keep_s   = 1'b0;
        keep_c   = 1'b0;
        mode_mid = mode_reg;
        if (!drop)
        begin
            case (mode_reg)
                M_NORMAL:
                begin
                    if (ch == csb_pkg::CH_HASH)
                        mode_mid = M_LINE;
                    else if (ch == csb_pkg::CH_SLASH)
                        mode_mid = M_SLASH;
                    else
                        keep_c = 1'b1;
                end
                M_SLASH:
                begin
                    if (ch == csb_pkg::CH_SLASH)
                        mode_mid = M_LINE;
                    else if (ch == csb_pkg::CH_STAR)
                        mode_mid = M_BLOCK;
                    else
                    begin
                        keep_s = 1'b1;
                        if (ch == csb_pkg::CH_HASH)
                            mode_mid = M_LINE;
                        else
                        begin
                            mode_mid = M_NORMAL;
                            keep_c   = 1'b1;
                        end
                    end
                end
                M_LINE:
                begin
                    if (ch == csb_pkg::CH_NL)
                        mode_mid = M_NORMAL;
                end
                M_BLOCK:
                begin
                    if (ch == csb_pkg::CH_STAR)
                        mode_mid = M_STAR;
                end
                M_STAR:
                begin
                    if (ch == csb_pkg::CH_SLASH)
                        mode_mid = M_NORMAL;
                    else if (ch != csb_pkg::CH_STAR)
                        mode_mid = M_BLOCK;
                end
                default:
                begin
                    mode_mid = M_NORMAL;
                end
            endcase
        end
        // A slash still pending at the final byte is kept.
        if (last_char && (mode_mid == M_SLASH))
            keep_s = 1'b1;
        mode_next = last_char ? M_NORMAL : mode_mid;
    end

    // Scanner: a kept slash first, then the kept byte itself.
    always_comb
    begin
        kept_mid  = keep_s ? kept_reg + POS_BITS'(1) : kept_reg;
        ident_mid = keep_s ? 1'b0 : ident_reg;

        // Repeated spaces and newlines collapse into one.
        c_kept = keep_c && !(((ch == csb_pkg::CH_SPACE) || (ch == csb_pkg::CH_NL))
                             && (ch == (keep_s ? csb_pkg::CH_SLASH : last_kept_reg)));

        kept_next        = c_kept ? kept_mid + POS_BITS'(1) : kept_mid;
        last_kept_next   = c_kept ? ch : (keep_s ? csb_pkg::CH_SLASH : last_kept_reg);
        ident_next       = ident_mid;
        ident_start_next = ident_start_reg;
        line_next        = line_reg;
        is_open          = 1'b0;
        is_close         = 1'b0;

        // Identifier closed by a kept slash or by a byte that cannot continue it.
        e1_v   = keep_s && ident_reg;
        e1_end = kept_reg;

        if (c_kept)
        begin
            if (c_alpha)
            begin
                if (!ident_mid)
                begin
                    ident_next       = 1'b1;
                    ident_start_next = kept_mid;
                end
            end
            else if (!(ident_mid && c_digit))
            begin
                if (ident_mid)
                begin
                    e1_v   = 1'b1;
                    e1_end = kept_mid;
                end
                ident_next = 1'b0;
                is_open    = (ch == csb_pkg::CH_LBRACE);
                is_close   = (ch == csb_pkg::CH_RBRACE);
                if ((ch == csb_pkg::CH_NL) && (line_reg != {POS_BITS{1'b1}}))
                    line_next = line_reg + POS_BITS'(1);
            end
        end

        // Final flush of an identifier still open.
        e2_v = last_char && ident_next;
        if (last_char)
            ident_next = 1'b0;
    end

    // Brace result.
    always_comb
    begin
        b_v      = is_open || is_close;
        b_kind   = csb_pkg::KIND_IDENT;
        b_block  = '0;
        b_parent = '0;
        b_link   = 1'b0;
        if (is_open)
        begin
            if (stat.full)
                b_kind = csb_pkg::KIND_OVERFLOW;
            else
            begin
                b_kind   = csb_pkg::KIND_OPEN;
                b_block  = next_id_reg;
                b_parent = encl_id;
                b_link   = !stat.empty;
            end
        end
        else if (is_close)
        begin
            if (stat.empty)
                b_kind = csb_pkg::KIND_UNMATCHED;
            else
            begin
                b_kind  = csb_pkg::KIND_CLOSE;
                b_block = tos;
            end
        end
    end

    // Stack requests; only taken on an input transfer.
    assign op.push = fire && is_open && !stat.full;
    assign op.pop  = fire && is_close && !stat.empty;
    assign push_id = next_id_reg;

    // Result packing and ordering; the last-of-run bit is the low bit.
    always_comb
    begin
        e1_pack = {csb_pkg::KIND_IDENT, ident_start_reg, e1_end, encl_id, {ID_BITS{1'b0}},
                   !stat.empty, line_reg, 1'b0};
        e2_pack = {csb_pkg::KIND_IDENT, ident_start_next, kept_next, encl_id,
                   {ID_BITS{1'b0}}, !stat.empty, line_reg, 1'b0};
        b_pack  = {b_kind, kept_mid, kept_mid, b_block, b_parent, b_link, line_reg, 1'b0};

        tail_pack = b_v ? b_pack[DATA_W-1:1] : e2_pack[DATA_W-1:1];
        if (e1_v)
        begin
            res0 = {e1_pack[DATA_W-1:1], !(b_v || e2_v)};
            res1 = {tail_pack, 1'b1};
        end
        else
        begin
            res0 = {tail_pack, 1'b1};
            res1 = {tail_pack, 1'b1};
        end

        if (!fire)
            res_n = 2'd0;
        else
            res_n = 2'(e1_v) + 2'(b_v || e2_v);
    end

    // Lexer state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= M_NORMAL;
            last_kept_reg   <= '0;
            kept_reg        <= '0;
            line_reg        <= POS_BITS'(1);
            ident_reg       <= 1'b0;
            ident_start_reg <= '0;
            next_id_reg     <= '0;
        end
        else if (fire)
        begin
            mode_reg        <= mode_next;
            last_kept_reg   <= last_kept_next;
            kept_reg        <= kept_next;
            line_reg        <= line_next;
            ident_reg       <= ident_next;
            ident_start_reg <= ident_start_next;
            if (op.push)
                next_id_reg <= next_id_reg + ID_BITS'(1);
        end
    end

endmodule
`default_nettype wire
